/* hdl/usbhid_pkg.sv */
// usbhid_pkg: constants, codes and the result record type of the hid descriptor scanner
// no dependencies; imported by usb_hid_descriptor_scanner
`default_nettype none

package usbhid_pkg;

  localparam int DEFAULT_MAX_PIPES = 3;

  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] CLASS_HID      = 8'h03;
  localparam logic [7:0] PROTO_KEYBOARD = 8'h01;
  localparam logic [7:0] PROTO_MOUSE    = 8'h02;

  localparam logic [1:0] EP_INTERRUPT   = 2'b11;

  localparam logic KIND_PIPE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] USAGE_KEYBOARD = 2'd0;
  localparam logic [1:0] USAGE_MOUSE    = 2'd1;
  localparam logic [1:0] USAGE_OTHER    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  itf;
    logic [7:0]  ep_addr;
    logic [15:0] mps;
    logic [1:0]  usage;
    logic [1:0]  count;
    logic        fin;
  } rec_t;

endpackage

`default_nettype wire

/* hdl/usb_hid_descriptor_scanner.sv */
// usb_hid_descriptor_scanner: walks a usb configuration descriptor byte by byte and
// reports interrupt-in pipes of hid interfaces plus an end-of-scan summary
// depends on usbhid_pkg
//
// input channel: in_valid/in_ready carry data_byte and end_of_block, one byte per transfer.
// output channel: out_valid/out_ready carry one record per transfer: a pipe record
// (record_kind 0) or the summary (record_kind 1) that follows the byte marked end_of_block.
// a record is shown the cycle after the byte that causes it, if no earlier record waits.
// throughput: one byte per cycle while in_ready is high; the descriptor walk is one
// pass of small compares between the input and a three-entry result queue. only the
// end_of_block byte that also completes a pipe yields two records and may drop in_ready.
// in_ready is high while the result queue holds at most one record, so bytes keep
// flowing while a finished record waits; a stalled receiver lets two records pile up
// and then in_ready drops until records are taken.
// reset (rst, synchronous) empties the queue and clears the scan state; end_of_block
// returns the scan state to its reset value as well.
// up to MAX_PIPES distinct hid interfaces get a pipe; the scan then stops until
// end_of_block.
`default_nettype none

module usb_hid_descriptor_scanner
  import usbhid_pkg::*;
#(
  parameter int MAX_PIPES = DEFAULT_MAX_PIPES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_kind,
  output logic [7:0]       interface_number,
  output logic [7:0]       endpoint_address,
  output logic [15:0]      max_packet,
  output logic [1:0]       usage_kind,
  output logic [1:0]       pipes_found,
  output logic             final_record
);

  localparam int CW = $clog2(MAX_PIPES + 1);
  localparam int QD = 3;

  // scan state
  logic [15:0]   byte_offset, byte_offset_next;
  logic [15:0]   block_length, block_length_next;
  logic [15:0]   desc_start, desc_start_next;
  logic [7:0]    desc_type, desc_type_next;
  logic [7:0]    desc_len, desc_len_next;
  logic          have_itf, have_itf_next;
  logic [7:0]    cur_itf, cur_itf_next;
  logic [7:0]    cur_class, cur_class_next;
  logic [7:0]    cur_proto, cur_proto_next;
  logic [7:0]    ep_addr, ep_addr_next;
  logic [7:0]    ep_attr, ep_attr_next;
  logic [7:0]    ep_mps_lo, ep_mps_lo_next;
  logic [7:0]    taken [MAX_PIPES];
  logic [CW-1:0] pipe_count, pipe_count_next;
  logic          stopped, stopped_next;

  // result queue
  rec_t          q [QD];
  rec_t          q_next [QD];
  logic [1:0]    q_count, q_count_next;

  logic          in_fire, out_fire;
  logic          pipe_hit, already_taken, take_write;
  logic [15:0]   rel;
  logic [CW+1:0] count_ext;
  logic [1:0]    usage;
  rec_t          rec0, rec1;
  logic [1:0]    n_rec;
  logic [1:0]    base;

  assign in_ready  = (q_count <= 2'd1);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (q_count != 2'd0);
  assign out_fire  = out_valid && out_ready;

  assign record_kind      = q[0].kind;
  assign interface_number = q[0].itf;
  assign endpoint_address = q[0].ep_addr;
  assign max_packet       = q[0].mps;
  assign usage_kind       = q[0].usage;
  assign pipes_found      = q[0].count;
  assign final_record     = q[0].fin;

  always_comb begin
    already_taken = 1'b0;
    for (int i = 0; i < MAX_PIPES; i++) begin
      if ((CW'(i) < pipe_count) && (taken[i] == cur_itf)) begin
        already_taken = 1'b1;
      end
    end
  end

  always_comb begin
    case (cur_proto)
      PROTO_KEYBOARD: usage = USAGE_KEYBOARD;
      PROTO_MOUSE:    usage = USAGE_MOUSE;
      default:        usage = USAGE_OTHER;
    endcase
  end

  // one pass over the incoming byte
  always_comb begin
    byte_offset_next  = byte_offset;
    block_length_next = block_length;
    desc_start_next   = desc_start;
    desc_type_next    = desc_type;
    desc_len_next     = desc_len;
    have_itf_next     = have_itf;
    cur_itf_next      = cur_itf;
    cur_class_next    = cur_class;
    cur_proto_next    = cur_proto;
    ep_addr_next      = ep_addr;
    ep_attr_next      = ep_attr;
    ep_mps_lo_next    = ep_mps_lo;
    pipe_count_next   = pipe_count;
    stopped_next      = stopped;
    pipe_hit          = 1'b0;
    take_write        = 1'b0;
    rel               = '0;

    if (!stopped) begin
      if (byte_offset == 16'd2) begin
        block_length_next[7:0] = data_byte;
      end
      if (byte_offset == 16'd3) begin
        block_length_next[15:8] = data_byte;
      end
      if ({1'b0, byte_offset} == {1'b0, desc_start} + {9'd0, desc_len}) begin
        desc_start_next = byte_offset;
        desc_len_next   = data_byte;
        desc_type_next  = '0;
      end
      if (((byte_offset >= 16'd3) &&
           ({1'b0, desc_start_next} + 17'd2 > {1'b0, block_length_next})) ||
          (desc_len_next == 8'd0)) begin
        stopped_next = 1'b1;
      end else begin
        rel = byte_offset - desc_start_next;
        case (rel)
          16'd1: begin
            desc_type_next = data_byte;
            if (data_byte == TYPE_INTERFACE) begin
              have_itf_next  = 1'b1;
              cur_itf_next   = '0;
              cur_class_next = '0;
              cur_proto_next = '0;
            end
          end
          16'd2: begin
            if (desc_type_next == TYPE_INTERFACE) begin
              cur_itf_next = data_byte;
            end else if (desc_type_next == TYPE_ENDPOINT) begin
              ep_addr_next   = data_byte;
              ep_attr_next   = '0;
              ep_mps_lo_next = '0;
            end
          end
          16'd3: begin
            if (desc_type_next == TYPE_ENDPOINT) begin
              ep_attr_next = data_byte;
            end
          end
          16'd4: begin
            if (desc_type_next == TYPE_ENDPOINT) begin
              ep_mps_lo_next = data_byte;
            end
          end
          16'd5: begin
            if (desc_type_next == TYPE_INTERFACE) begin
              cur_class_next = data_byte;
            end else if (desc_type_next == TYPE_ENDPOINT) begin
              if (have_itf && (cur_class == CLASS_HID) && ep_addr[7] &&
                  (ep_attr[1:0] == EP_INTERRUPT) && (pipe_count < CW'(MAX_PIPES)) &&
                  !already_taken) begin
                pipe_hit        = 1'b1;
                take_write      = 1'b1;
                pipe_count_next = pipe_count + CW'(1);
                if (pipe_count_next >= CW'(MAX_PIPES)) begin
                  stopped_next = 1'b1;
                end
              end
            end
          end
          16'd7: begin
            if (desc_type_next == TYPE_INTERFACE) begin
              cur_proto_next = data_byte;
            end
          end
          default: begin
          end
        endcase
        if (byte_offset == 16'hFFFF) begin
          stopped_next = 1'b1;
        end else begin
          byte_offset_next = byte_offset + 16'd1;
        end
      end
    end

    count_ext = {2'b00, pipe_count_next};

    rec0 = '0;
    rec1 = '0;
    rec1.kind  = KIND_SUMMARY;
    rec1.count = count_ext[1:0];
    rec1.fin   = 1'b1;
    if (pipe_hit) begin
      rec0.kind    = KIND_PIPE;
      rec0.itf     = cur_itf;
      rec0.ep_addr = ep_addr;
      rec0.mps     = {data_byte, ep_mps_lo};
      rec0.usage   = usage;
      rec0.count   = count_ext[1:0];
      rec0.fin     = !end_of_block;
      n_rec        = end_of_block ? 2'd2 : 2'd1;
    end else if (end_of_block) begin
      rec0  = rec1;
      n_rec = 2'd1;
    end else begin
      n_rec = 2'd0;
    end
  end

  // result queue, head at entry 0
  always_comb begin
    base = q_count - {1'b0, out_fire};
    for (int i = 0; i < QD; i++) begin
      if (out_fire && (i < QD - 1)) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (in_fire && (n_rec != 2'd0) && (2'(i) == base)) begin
        q_next[i] = rec0;
      end
      if (in_fire && (n_rec == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_next[i] = rec1;
      end
    end
    q_count_next = base + (in_fire ? n_rec : 2'd0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q[i] <= q_next[i];
    end
    if (in_fire && take_write) begin
      for (int i = 0; i < MAX_PIPES; i++) begin
        if (CW'(i) == pipe_count) begin
          taken[i] <= cur_itf;
        end
      end
    end
    if (rst) begin
      q_count      <= '0;
      byte_offset  <= '0;
      block_length <= '0;
      desc_start   <= '0;
      desc_type    <= '0;
      desc_len     <= '0;
      have_itf     <= 1'b0;
      cur_itf      <= '0;
      cur_class    <= '0;
      cur_proto    <= '0;
      ep_addr      <= '0;
      ep_attr      <= '0;
      ep_mps_lo    <= '0;
      pipe_count   <= '0;
      stopped      <= 1'b0;
    end else begin
      q_count <= q_count_next;
      if (in_fire) begin
        if (end_of_block) begin
          byte_offset  <= '0;
          block_length <= '0;
          desc_start   <= '0;
          desc_type    <= '0;
          desc_len     <= '0;
          have_itf     <= 1'b0;
          cur_itf      <= '0;
          cur_class    <= '0;
          cur_proto    <= '0;
          ep_addr      <= '0;
          ep_attr      <= '0;
          ep_mps_lo    <= '0;
          pipe_count   <= '0;
          stopped      <= 1'b0;
        end else begin
          byte_offset  <= byte_offset_next;
          block_length <= block_length_next;
          desc_start   <= desc_start_next;
          desc_type    <= desc_type_next;
          desc_len     <= desc_len_next;
          have_itf     <= have_itf_next;
          cur_itf      <= cur_itf_next;
          cur_class    <= cur_class_next;
          cur_proto    <= cur_proto_next;
          ep_addr      <= ep_addr_next;
          ep_attr      <= ep_attr_next;
          ep_mps_lo    <= ep_mps_lo_next;
          pipe_count   <= pipe_count_next;
          stopped      <= stopped_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// tb: self-checking bench for usb_hid_descriptor_scanner, driving descriptor bytes on
// the valid/ready input channel and checking every record against its own scan predictor
// depends on usbhid_pkg and hdl/usb_hid_descriptor_scanner.sv
module tb;
  import usbhid_pkg::*;

  localparam int PIPE_SLOTS = DEFAULT_MAX_PIPES;
  localparam logic [7:0] TYPE_CONFIG    = 8'h02;
  localparam logic [7:0] TYPE_HID_CLASS = 8'h21;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic [7:0] b;
    logic       eob;
    logic [1:0] typed;
  } stim_row_t;

  typedef enum logic [1:0] {DRAIN_FREE, DRAIN_COIN, DRAIN_SLOW, DRAIN_BEAT} drain_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        record_kind;
  logic [7:0]  interface_number;
  logic [7:0]  endpoint_address;
  logic [15:0] max_packet;
  logic [1:0]  usage_kind;
  logic [1:0]  pipes_found;
  logic        final_record;

  // scan state of the predictor
  logic [15:0] scan_pos;
  logic [15:0] total_len;
  logic [15:0] desc_base;
  logic [7:0]  desc_kind;
  logic [7:0]  desc_len;
  logic        itf_seen;
  logic [7:0]  itf_num;
  logic [7:0]  itf_class;
  logic [7:0]  itf_proto;
  logic [23:0] ep_fields;
  logic [7:0]  claimed_itf [PIPE_SLOTS];
  int          pipe_total;
  logic        halted;

  rec_t        step_out [2];
  rec_t        due_records [$];
  rec_t        head_record;
  logic [7:0]  block_bytes [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          typed_next = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  // directed bytes: lone zero, a keyboard pipe at the field extremes, a short total length
  stim_row_t directed_rows [24] = '{
    '{8'h00, 1'b1, 2'd1},
    '{8'h04, 1'b0, 2'd0}, '{TYPE_CONFIG, 1'b0, 2'd0}, '{8'h12, 1'b0, 2'd0},
    '{8'h00, 1'b0, 2'd0},
    '{8'h08, 1'b0, 2'd0}, '{TYPE_INTERFACE, 1'b0, 2'd0}, '{8'hFF, 1'b0, 2'd0},
    '{8'h00, 1'b0, 2'd0}, '{8'h01, 1'b0, 2'd0}, '{CLASS_HID, 1'b0, 2'd0},
    '{8'h01, 1'b0, 2'd0}, '{PROTO_KEYBOARD, 1'b0, 2'd0},
    '{8'h06, 1'b0, 2'd0}, '{TYPE_ENDPOINT, 1'b0, 2'd0}, '{8'h81, 1'b0, 2'd0},
    '{8'hFF, 1'b0, 2'd0}, '{8'hFF, 1'b0, 2'd0}, '{8'hFF, 1'b1, 2'd2},
    '{8'h04, 1'b0, 2'd0}, '{TYPE_CONFIG, 1'b0, 2'd0}, '{8'h03, 1'b0, 2'd0},
    '{8'h00, 1'b0, 2'd0}, '{8'h55, 1'b1, 2'd1}
  };

  rec_t typed_records [4] = '{
    '{KIND_SUMMARY, 8'h00, 8'h00, 16'h0000, 2'd0, 2'd0, 1'b1},
    '{KIND_PIPE, 8'hFF, 8'h81, 16'hFFFF, USAGE_KEYBOARD, 2'd1, 1'b0},
    '{KIND_SUMMARY, 8'h00, 8'h00, 16'h0000, 2'd0, 2'd1, 1'b1},
    '{KIND_SUMMARY, 8'h00, 8'h00, 16'h0000, 2'd0, 2'd0, 1'b1}
  };

  usb_hid_descriptor_scanner i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .end_of_block     (end_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .record_kind      (record_kind),
    .interface_number (interface_number),
    .endpoint_address (endpoint_address),
    .max_packet       (max_packet),
    .usage_kind       (usage_kind),
    .pipes_found      (pipes_found),
    .final_record     (final_record)
  );

  always #5 clk = ~clk;

  function automatic void clear_scan();
    int i;
    scan_pos = '0;
    total_len = '0;
    desc_base = '0;
    desc_kind = '0;
    desc_len = '0;
    itf_seen = 1'b0;
    itf_num = '0;
    itf_class = '0;
    itf_proto = '0;
    ep_fields = '0;
    for (i = 0; i < PIPE_SLOTS; i++) claimed_itf[i] = '0;
    pipe_total = 0;
    halted = 1'b0;
  endfunction

  // max packet high byte of an endpoint descriptor: maybe a new pipe
  function automatic int close_endpoint(input logic [7:0] last);
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [15:0] mps;
    logic [1:0]  usage;
    int          i;
    addr = ep_fields[7:0];
    attr = ep_fields[15:8];
    mps = {last, ep_fields[23:16]};
    if (!itf_seen || itf_class != CLASS_HID) return 0;
    if (!addr[7] || attr[1:0] != EP_INTERRUPT) return 0;
    if (pipe_total >= PIPE_SLOTS) return 0;
    for (i = 0; i < pipe_total; i++)
      if (claimed_itf[i] == itf_num) return 0;
    claimed_itf[pipe_total] = itf_num;
    pipe_total++;
    if (itf_proto == PROTO_KEYBOARD) usage = USAGE_KEYBOARD;
    else if (itf_proto == PROTO_MOUSE) usage = USAGE_MOUSE;
    else usage = USAGE_OTHER;
    step_out[0] = '{KIND_PIPE, itf_num, addr, mps, usage, 2'(pipe_total), 1'b1};
    if (pipe_total >= PIPE_SLOTS) halted = 1'b1;
    return 1;
  endfunction

  // advances the scan by one byte, leaves the records it causes in step_out
  function automatic int scan_byte(input logic [7:0] b, input logic eob);
    int n;
    int rel;
    n = 0;
    if (!halted) begin
      if (scan_pos == 16'd2) total_len[7:0] = b;
      if (scan_pos == 16'd3) total_len[15:8] = b;
      if (int'(scan_pos) == int'(desc_base) + int'(desc_len)) begin
        desc_base = scan_pos;
        desc_len = b;
        desc_kind = '0;
      end
      if ((scan_pos >= 16'd3 && int'(desc_base) + 2 > int'(total_len)) || desc_len == 8'd0) begin
        halted = 1'b1;
      end else begin
        rel = int'(scan_pos) - int'(desc_base);
        case (rel)
          1: begin
            desc_kind = b;
            if (b == TYPE_INTERFACE) begin
              itf_seen = 1'b1;
              itf_num = '0;
              itf_class = '0;
              itf_proto = '0;
            end
          end
          2: begin
            if (desc_kind == TYPE_INTERFACE) itf_num = b;
            else if (desc_kind == TYPE_ENDPOINT) ep_fields = {16'h0000, b};
          end
          3: if (desc_kind == TYPE_ENDPOINT) ep_fields[15:8] = b;
          4: if (desc_kind == TYPE_ENDPOINT) ep_fields[23:16] = b;
          5: begin
            if (desc_kind == TYPE_INTERFACE) itf_class = b;
            else if (desc_kind == TYPE_ENDPOINT) n = close_endpoint(b);
          end
          7: if (desc_kind == TYPE_INTERFACE) itf_proto = b;
          default: ;
        endcase
        if (scan_pos == 16'hFFFF) halted = 1'b1;
        else scan_pos = scan_pos + 16'd1;
      end
    end
    if (eob) begin
      if (n > 0) step_out[0].fin = 1'b0;
      step_out[n] = '{KIND_SUMMARY, 8'h00, 8'h00, 16'h0000, 2'd0, 2'(pipe_total), 1'b1};
      n++;
      clear_scan();
    end
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob, input int typed);
    int idle;
    int n;
    int i;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    n = scan_byte(b, eob);
    if (typed == 0) begin
      for (i = 0; i < n; i++) due_records.push_back(step_out[i]);
    end else begin
      for (i = 0; i < typed; i++) due_records.push_back(typed_records[typed_next + i]);
      typed_next += typed;
    end
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < block_bytes.size(); i++)
      send_byte(block_bytes[i], i == block_bytes.size() - 1, 0);
  endtask

  task automatic add_descriptor();
    logic [7:0] body [9];
    int         len;
    int         pick;
    int         i;
    pick = $urandom_range(0, 9);
    for (i = 0; i < 9; i++) body[i] = 8'($urandom);
    len = 9;
    if (pick < 4) begin
      body[1] = TYPE_INTERFACE;
      if ($urandom_range(0, 4) != 0) body[2] = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) body[5] = CLASS_HID;
      case ($urandom_range(0, 2))
        0: body[7] = PROTO_KEYBOARD;
        1: body[7] = PROTO_MOUSE;
        default: ;
      endcase
    end else if (pick < 8) begin
      len = 7;
      body[1] = TYPE_ENDPOINT;
      if ($urandom_range(0, 5) != 0) body[2][7] = 1'b1;
      if ($urandom_range(0, 4) != 0) body[3][1:0] = EP_INTERRUPT;
    end else if (pick == 8) begin
      body[1] = TYPE_HID_CLASS;
    end else begin
      len = $urandom_range(0, 12);
    end
    if ($urandom_range(0, 11) == 0) len = $urandom_range(1, 12);
    if ($urandom_range(0, 149) == 0) len = $urandom_range(13, 255);
    body[0] = 8'(len);
    if (len == 0) block_bytes.push_back(8'h00);
    for (i = 0; i < len; i++) block_bytes.push_back(i < 9 ? body[i] : 8'($urandom));
  endtask

  task automatic build_block();
    int          hdr_len;
    int          keep;
    int          i;
    logic [15:0] total;
    block_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) block_bytes.push_back(8'($urandom));
    end else begin
      hdr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : 9;
      block_bytes.push_back(8'(hdr_len));
      block_bytes.push_back(TYPE_CONFIG);
      block_bytes.push_back(8'h00);
      block_bytes.push_back(8'h00);
      for (i = 4; i < hdr_len; i++) block_bytes.push_back(8'($urandom));
      repeat ($urandom_range(1, 14)) add_descriptor();
      total = 16'(block_bytes.size());
      case ($urandom_range(0, 7))
        0: total = 16'($urandom_range(0, block_bytes.size()));
        1: total = total + 16'($urandom_range(1, 20));
        2: total = 16'($urandom);
        default: ;
      endcase
      block_bytes[2] = total[7:0];
      block_bytes[3] = total[15:8];
      case ($urandom_range(0, 7))
        0: begin
          keep = $urandom_range(1, block_bytes.size());
          while (block_bytes.size() > keep) void'(block_bytes.pop_back());
        end
        1: repeat ($urandom_range(1, 12)) block_bytes.push_back(8'($urandom));
        default: ;
      endcase
    end
  endtask

  function automatic void check_field(input string label, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_records.size() == 0) begin
        $display("%0t: record with none expected, kind %0d actual", $time, record_kind);
        mismatches++;
      end else begin
        head_record = due_records.pop_front();
        check_field("record_kind", head_record.kind, record_kind);
        check_field("interface_number", head_record.itf, interface_number);
        check_field("endpoint_address", head_record.ep_addr, endpoint_address);
        check_field("max_packet", head_record.mps, max_packet);
        check_field("usage_kind", head_record.usage, usage_kind);
        check_field("pipes_found", head_record.count, pipes_found);
        check_field("final_record", head_record.fin, final_record);
      end
    end
  end

  // receiver backpressure in phases of random length
  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 3));
      drain_left <= $urandom_range(16, 240);
    end else begin
      drain_left <= drain_left - 1;
    end
    case (drain_mode)
      DRAIN_FREE: out_ready <= 1'b1;
      DRAIN_COIN: out_ready <= ($urandom_range(0, 1) == 1);
      DRAIN_SLOW: out_ready <= ($urandom_range(0, 5) == 0);
      default:    out_ready <= (drain_left % 5 != 0);
    endcase
  end

  initial begin
    int row;
    clear_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < 24; row++)
      send_byte(directed_rows[row].b, directed_rows[row].eob, int'(directed_rows[row].typed));

    // sender holds off until the scanner has drained
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_records.size() != 0);

    while (items_sent < RANDOM_ITEMS + 24) begin
      build_block();
      send_block();
    end

    in_valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("tb: failure");
    $finish;
  end

endmodule
